[rtl/core/aarc_pkg.sv]
// ----------------------------------------------------------------------------
// ADC auto-range controller package
// Shared widths, register indexes, action codes and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package aarc_pkg;

  // Number of gain steps of the amplifier (2 to 16).
  localparam int GAIN_STEPS = 16;
  localparam int GAIN_W     = (GAIN_STEPS > 2) ? $clog2(GAIN_STEPS) : 1;
  // The search counter must hold GAIN_STEPS itself.
  localparam int CNT_W      = $clog2(GAIN_STEPS + 1);

  localparam int SMP_W      = 8;
  localparam int OFS_W      = 12;
  localparam int ACT_W      = 2;
  localparam int PROD_W     = SMP_W + CNT_W;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_ADDR_W-1:0] REG_CLIP_HIGH   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CLIP_LOW    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CENTER_TOL  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPAN_TARGET = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_HOME = 3'd4;

  // Reset values.
  localparam logic [SMP_W-1:0] CLIP_HIGH_RST   = 8'd250;
  localparam logic [SMP_W-1:0] CLIP_LOW_RST    = 8'd5;
  localparam logic [SMP_W-1:0] CENTER_TOL_RST  = 8'd5;
  localparam logic [SMP_W-1:0] SPAN_TARGET_RST = 8'd245;
  localparam logic [OFS_W-1:0] OFFSET_HOME_RST = 12'd2047;
  localparam logic [OFS_W-1:0] OFFSET_MAX      = 12'd4095;

  // Ideal max plus min of a centered block.
  localparam logic [SMP_W:0] CENTER_SUM = 9'd254;

  // Action codes reported with each result.
  localparam logic [ACT_W-1:0] ACT_GAIN   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CLIP   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_OFFSET = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_sample;  // accumulate the sample on the input channel
    logic decide;       // judge the finished block
    logic search_step;  // one step of the gain search
    logic publish;      // load the output register and start a new block
  } aarc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic search_needed;  // block is neither clipped nor off center
    logic search_done;    // gain search has found its stopping point
    logic out_free;       // output register can take a new result
  } aarc_sts_t;

endpackage

[rtl/core/aarc_ctrl.sv]
// ----------------------------------------------------------------------------
// ADC auto-range controller sequencer
// One-hot state machine that collects a block, runs the decision and the
// gain search, and hands the result to the output register.
// ----------------------------------------------------------------------------
module aarc_ctrl
  import aarc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  logic      in_tlast,
  output logic      in_tready,
  input  aarc_sts_t sts,
  output aarc_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_ACC  = 4'b0001,
    S_DEC  = 4'b0010,
    S_SRCH = 4'b0100,
    S_PUB  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Samples are taken only while a block is being collected.
  assign in_tready = (state_r == S_ACC);

  // Next state and commands.
  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.take_sample = (state_r == S_ACC) && in_tvalid;
    case (state_r)
      S_ACC: begin
        if (in_tvalid && in_tlast) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.decide = 1'b1;
        state_nxt  = sts.search_needed ? S_SRCH : S_PUB;
      end
      S_SRCH: begin
        if (sts.search_done) begin
          state_nxt = S_PUB;
        end else begin
          cmd.search_step = 1'b1;
        end
      end
      S_PUB: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = S_ACC;
        end
      end
      default: begin
        state_nxt = S_ACC;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACC;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/core/aarc_dp.sv]
// ----------------------------------------------------------------------------
// ADC auto-range controller datapath
// Configuration registers, block max and min tracking, clip and centering
// decision, iterative gain search and the output register.
// ----------------------------------------------------------------------------
module aarc_dp
  import aarc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [SMP_W-1:0]      sample,
  input  aarc_cmd_t             cmd,
  output aarc_sts_t             sts,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic [31:0]           out_tdata,
  output logic [ACT_W-1:0]      out_tuser
);

  // Configuration registers.
  logic [SMP_W-1:0] clip_high_r, clip_low_r, center_tol_r, span_target_r;
  logic [OFS_W-1:0] offset_home_r;

  // Block and setting state.
  logic [SMP_W-1:0]  max_r, min_r;
  logic              started_r;
  logic [OFS_W-1:0]  offset_r;
  logic [GAIN_W-1:0] gain_r;
  logic [ACT_W-1:0]  act_r;
  logic [CNT_W-1:0]  step_r;
  logic [PROD_W-1:0] limit_r;

  // Output register.
  logic              out_valid_r;
  logic [OFS_W-1:0]  out_offset_r;
  logic [GAIN_W-1:0] out_gain_r;
  logic [SMP_W-1:0]  out_max_r, out_min_r;
  logic [ACT_W-1:0]  out_act_r;

  // Decision logic.
  logic              clip_hit;
  logic [SMP_W:0]    sum;
  logic [SMP_W:0]    center_err;
  logic              off_center;
  logic signed [14:0] offset_new;
  logic [OFS_W-1:0]  offset_sat;
  logic [SMP_W-1:0]  span;
  logic [PROD_W-1:0] limit_nxt;
  logic [PROD_W-1:0] step_prod;
  logic [CNT_W-1:0]  step_plus1;

  assign clip_hit   = (max_r > clip_high_r) || (min_r < clip_low_r);
  assign sum        = {1'b0, max_r} + {1'b0, min_r};
  assign center_err = (sum > CENTER_SUM) ? (sum - CENTER_SUM) : (CENTER_SUM - sum);
  assign off_center = center_err > {1'b0, center_tol_r};

  // New offset is offset - 2*(sum - 254), saturated to the DAC range.
  assign offset_new = $signed({3'b000, offset_r}) - $signed({5'b00000, sum, 1'b0})
                    + 15'sd508;
  always_comb begin
    if (offset_new < 15'sd0) begin
      offset_sat = '0;
    end else if (offset_new > $signed({3'b000, OFFSET_MAX})) begin
      offset_sat = OFFSET_MAX;
    end else begin
      offset_sat = offset_new[OFS_W-1:0];
    end
  end

  // Gain search: step i is allowed while (i+1)*span <= target*(g0+1).
  // Both products are formed at the full product width.
  assign span       = max_r - min_r;
  assign limit_nxt  = PROD_W'(span_target_r)
                    * PROD_W'({{(CNT_W-GAIN_W){1'b0}}, gain_r} + CNT_W'(1));
  assign step_plus1 = step_r + CNT_W'(1);
  assign step_prod  = PROD_W'(step_plus1) * PROD_W'(span);

  assign sts.search_needed = !clip_hit && !off_center;
  assign sts.search_done   = (step_r >= CNT_W'(GAIN_STEPS)) || (step_prod > limit_r);
  assign sts.out_free      = !out_valid_r || out_tready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_high_r   <= CLIP_HIGH_RST;
      clip_low_r    <= CLIP_LOW_RST;
      center_tol_r  <= CENTER_TOL_RST;
      span_target_r <= SPAN_TARGET_RST;
      offset_home_r <= OFFSET_HOME_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CLIP_HIGH:   clip_high_r   <= cfg_wdata[SMP_W-1:0];
        REG_CLIP_LOW:    clip_low_r    <= cfg_wdata[SMP_W-1:0];
        REG_CENTER_TOL:  center_tol_r  <= cfg_wdata[SMP_W-1:0];
        REG_SPAN_TARGET: span_target_r <= cfg_wdata[SMP_W-1:0];
        REG_OFFSET_HOME: offset_home_r <= cfg_wdata[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  // Block tracking, decision and search.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r     <= '0;
      min_r     <= '1;
      started_r <= 1'b0;
      offset_r  <= OFFSET_HOME_RST;
      gain_r    <= '0;
      act_r     <= ACT_GAIN;
    end else begin
      if (cmd.take_sample) begin
        started_r <= 1'b1;
        if (!started_r) begin
          max_r <= sample;
          min_r <= sample;
        end else begin
          if (sample > max_r) max_r <= sample;
          if (sample < min_r) min_r <= sample;
        end
      end
      if (cmd.decide) begin
        if (clip_hit) begin
          offset_r <= offset_home_r;
          gain_r   <= '0;
          act_r    <= ACT_CLIP;
        end else if (off_center) begin
          offset_r <= offset_sat;
          act_r    <= ACT_OFFSET;
        end else begin
          act_r    <= ACT_GAIN;
        end
      end
      if (cmd.search_step) begin
        gain_r <= step_r[GAIN_W-1:0];
      end
      if (cmd.publish) begin
        max_r     <= '0;
        min_r     <= '1;
        started_r <= 1'b0;
      end
    end
  end

  // Search counter and span limit need no reset.
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      step_r  <= {{(CNT_W-GAIN_W){1'b0}}, gain_r} + CNT_W'(1);
      limit_r <= limit_nxt;
    end else if (cmd.search_step) begin
      step_r  <= step_plus1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_offset_r <= offset_r;
      out_gain_r   <= gain_r;
      out_max_r    <= max_r;
      out_min_r    <= min_r;
      out_act_r    <= act_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_min_r, out_max_r, 4'(out_gain_r), out_offset_r};
  assign out_tuser  = out_act_r;

endmodule

[rtl/core/adc_auto_range_controller_unit.sv]
// ----------------------------------------------------------------------------
// ADC auto-range controller
// Tracks each block's max and min and adjusts offset and gain at block end.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter on the in_ stream, one per cycle while in_tready is high,
// with in_tlast on the final sample of a block. After the final sample,
// in_tready drops while the block is judged: first the clip and centering
// decision, then, when neither applies, a gain search that tries one gain
// step at a time, then the load of the output register. The next sample is
// taken only after that load.
// One result per block leaves on the out_ stream from a registered output.
// When the receiver stalls, the result is held and the block finishing next
// waits at its publish step; its samples were accepted, but no new ones are.
// Reset (rst_n, synchronous) restores the register defaults, sets the offset
// to its home code and the gain to zero, and empties the output register.
// The user makes configuration writes on cfg_ while the block is idle, unenforced.
// ----------------------------------------------------------------------------
module adc_auto_range_controller_unit
  import aarc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Sample stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] sample
  input  logic                  in_tlast,   // last_in_block
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // [11:0] offset_code, [15:12] gain_code,
                                            // [23:16] block_max, [31:24] block_min
  output logic [ACT_W-1:0]      out_tuser   // [1:0] action
);

  aarc_cmd_t cmd;
  aarc_sts_t sts;

  // Sequencer.
  aarc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath.
  aarc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .sample     (in_tdata[SMP_W-1:0]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTH
  // A block end stops sample intake while the decision runs.
  a_last_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !in_tready)
    else $error("sample accepted right after a block end");

  // A clip result always reports gain zero.
  a_clip_gain_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ACT_CLIP)) |-> (out_tdata[15:12] == 4'd0))
    else $error("clip result with nonzero gain");

  // Every block holds at least one sample, so its max is not below its min.
  a_max_ge_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[23:16] >= out_tdata[31:24]))
    else $error("block max below block min");

  // Only defined action codes are reported.
  a_action_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser == ACT_GAIN) || (out_tuser == ACT_CLIP)
                    || (out_tuser == ACT_OFFSET)))
    else $error("undefined action code");
`endif

endmodule
